// ----- design/tram_pkg.sv -----
package tram_pkg;

	// Default sizing of the meter.
	localparam int DEF_NUM_DIRECTIONS = 2;
	localparam int DEF_NUM_CATEGORIES = 16;
	localparam int DEF_FRACTION_BITS  = 10;

	// Field and register widths.
	localparam int BYTE_W     = 16;
	localparam int CAT_W      = 4;
	localparam int VAL_W      = 48;
	localparam int PERIOD_W   = 20;
	localparam int REGR_W     = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Milliseconds per second; 1000 fits in MS_SHIFT bits.
	localparam logic [9:0] MS_PER_SECOND = 10'd1000;
	localparam int         MS_SHIFT      = 10;
	localparam int         PROD_W        = VAL_W + MS_SHIFT;

	localparam logic [VAL_W-1:0] VAL_MAX = '1;

	// Request codes of the command channel.
	localparam logic REQ_COUNT = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_MS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REGRESSION = 2'd1;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd1000;
	localparam logic [REGR_W-1:0]   REGR_RESET   = 11'd16;

endpackage

// ----- design/tram_ram.sv -----
module tram_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/tram_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tram_div #(
	parameter int DVD_W = 58,
	parameter int DVS_W = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;

	logic [DVS_W:0]   rem_sh;
	logic [DVS_W+1:0] diff;
	logic             ge;

	// The remainder stays below the divisor, so the shifted value fits DVS_W+1 bits.
	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign ge     = ~diff[DVS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/traffic_rate_average_meter_core.sv -----
// Count item: the sum is read at the accepting edge and busy stays high for one cycle
// while the saturated sum is written back; an item for an out-of-range entry is dropped.
// Tick item: walks all NUM_DIRECTIONS*NUM_CATEGORIES entries; for each entry it reads,
// multiplies and runs three divisions on the shared bit-serial divider. One result
// strobe per entry.
// The receiver cannot stall: result_valid is high for exactly one cycle per result.
// Reset (arst_n low) is asynchronous; it clears all sums and averages through valid bits.
module traffic_rate_average_meter_core #(
	parameter int NUM_DIRECTIONS = tram_pkg::DEF_NUM_DIRECTIONS,
	parameter int NUM_CATEGORIES = tram_pkg::DEF_NUM_CATEGORIES,
	parameter int FRACTION_BITS  = tram_pkg::DEF_FRACTION_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Command channel.
	input  logic                             start,
	output logic                             busy,
	input  logic                             req_type,
	input  logic                             direction,
	input  logic [tram_pkg::CAT_W-1:0]       category,
	input  logic [tram_pkg::BYTE_W-1:0]      byte_count,
	// Configuration write port.
	input  logic                             cfg_we,
	input  logic [tram_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tram_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Result channel.
	output logic                             result_valid,
	output logic                             out_direction,
	output logic [tram_pkg::CAT_W-1:0]       out_category,
	output logic [tram_pkg::VAL_W-1:0]       rate,
	output logic [tram_pkg::VAL_W-1:0]       average,
	output logic                             last
);

	localparam int NUM_ENTRIES = NUM_DIRECTIONS * NUM_CATEGORIES;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int CAT_CNT_W   = $clog2(NUM_CATEGORIES);
	localparam int VAL_W       = tram_pkg::VAL_W;
	localparam int PROD_W      = tram_pkg::PROD_W;
	localparam int PERIOD_W    = tram_pkg::PERIOD_W;

	// The sequencer. A tick visits each entry with READ, MUL and three divisions.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT_ADD,
		ST_READ,
		ST_MUL,
		ST_DIV_RATE,
		ST_DIV_AVG,
		ST_DIV_INC
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [PERIOD_W-1:0]        period_q;
	logic [tram_pkg::REGR_W-1:0] regression_q;

	// Entry walk and item registers.
	logic [IDX_W-1:0]     idx_q;
	logic                 dir_q;
	logic [CAT_CNT_W-1:0] cat_q;
	logic [VAL_W-1:0]     add_q;

	// Per-entry valid bits; an entry that is not valid reads as zero.
	logic [NUM_ENTRIES-1:0] sum_vld_q;
	logic [NUM_ENTRIES-1:0] avg_vld_q;
	logic                   sum_vld_rd_q;
	logic                   avg_vld_rd_q;

	// Tick datapath registers.
	logic [PROD_W-1:0] prod_q;
	logic [VAL_W-1:0]  avg_old_q;
	logic [VAL_W-1:0]  rate_q;
	logic [VAL_W-1:0]  avg_dec_q;
	logic              div_start_q;

	// Memory ports.
	logic [IDX_W-1:0] rd_addr;
	logic [VAL_W-1:0] sum_rdata;
	logic [VAL_W-1:0] avg_rdata;
	logic             sum_we;
	logic             avg_we;

	// Combinational datapath.
	logic              accept;
	logic              in_range;
	logic [IDX_W-1:0]  in_idx;
	logic [VAL_W-1:0]  sum_cur;
	logic [VAL_W-1:0]  avg_cur;
	logic [VAL_W:0]    cnt_sum;
	logic [VAL_W-1:0]  cnt_new;
	logic [PROD_W-1:0] prod;
	logic [PERIOD_W-1:0] per_eff;
	logic [PERIOD_W-1:0] regr_eff;
	logic [PROD_W-1:0] div_dvd;
	logic [PERIOD_W-1:0] div_dvs;
	logic              div_done;
	logic [PROD_W-1:0] div_quo;
	logic [VAL_W-1:0]  quo_low;
	logic [VAL_W-1:0]  rate_sat;
	logic [VAL_W:0]    avg_sum;
	logic [VAL_W-1:0]  avg_new;
	logic              last_entry;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// Entries are laid out direction-major: direction times NUM_CATEGORIES plus category.
	assign in_range = (32'(direction) < NUM_DIRECTIONS) && (32'(category) < NUM_CATEGORIES);
	assign in_idx   = IDX_W'(32'(direction) * NUM_CATEGORIES + 32'(category));

	// In idle the memories look up the entry of the incoming item; otherwise the walk index.
	assign rd_addr = (state_q == ST_IDLE) ? in_idx : idx_q;

	assign sum_cur = sum_vld_rd_q ? sum_rdata : '0;
	assign avg_cur = avg_vld_rd_q ? avg_rdata : '0;

	// Saturating add of a count transfer.
	assign cnt_sum = {1'b0, sum_cur} + {1'b0, add_q};
	assign cnt_new = cnt_sum[VAL_W] ? tram_pkg::VAL_MAX : cnt_sum[VAL_W-1:0];

	// sum * 1000 written as sum * (1024 - 16 - 8).
	assign prod = (PROD_W'(sum_cur) << 10) - (PROD_W'(sum_cur) << 4)
		- (PROD_W'(sum_cur) << 3);

	// A zero period or regression behaves as one.
	assign per_eff  = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign regr_eff = (regression_q == '0) ? PERIOD_W'(1) : PERIOD_W'(regression_q);

	// Operand selection for the shared divider.
	always_comb begin
		case (state_q)
			ST_DIV_AVG: begin
				div_dvd = PROD_W'(avg_old_q);
				div_dvs = regr_eff;
			end
			ST_DIV_INC: begin
				div_dvd = PROD_W'(rate_q);
				div_dvs = regr_eff;
			end
			default: begin
				div_dvd = prod_q;
				div_dvs = per_eff;
			end
		endcase
	end

	tram_div #(
		.DVD_W (PROD_W),
		.DVS_W (PERIOD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Both divisions by the regression give quotients that fit the value width.
	assign quo_low  = div_quo[VAL_W-1:0];
	assign rate_sat = (div_quo > PROD_W'(tram_pkg::VAL_MAX)) ? tram_pkg::VAL_MAX : quo_low;
	assign avg_sum  = {1'b0, avg_dec_q} + {1'b0, quo_low};
	assign avg_new  = avg_sum[VAL_W] ? tram_pkg::VAL_MAX : avg_sum[VAL_W-1:0];

	assign last_entry = (dir_q == 1'(NUM_DIRECTIONS - 1))
		&& (cat_q == CAT_CNT_W'(NUM_CATEGORIES - 1));

	assign sum_we = (state_q == ST_CNT_ADD);
	assign avg_we = (state_q == ST_DIV_INC) && div_done;

	tram_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NUM_ENTRIES)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (idx_q),
		.wdata (cnt_new),
		.raddr (rd_addr),
		.rdata (sum_rdata)
	);

	tram_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NUM_ENTRIES)
	) u_avg_ram (
		.clk   (clk),
		.we    (avg_we),
		.waddr (idx_q),
		.wdata (avg_new),
		.raddr (rd_addr),
		.rdata (avg_rdata)
	);

	// Sequencer, configuration, valid bits and the result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			period_q      <= tram_pkg::PERIOD_RESET;
			regression_q  <= tram_pkg::REGR_RESET;
			idx_q         <= '0;
			dir_q         <= 1'b0;
			cat_q         <= '0;
			add_q         <= '0;
			sum_vld_q     <= '0;
			avg_vld_q     <= '0;
			sum_vld_rd_q  <= 1'b0;
			avg_vld_rd_q  <= 1'b0;
			prod_q        <= '0;
			avg_old_q     <= '0;
			rate_q        <= '0;
			avg_dec_q     <= '0;
			div_start_q   <= 1'b0;
			result_valid  <= 1'b0;
			out_direction <= 1'b0;
			out_category  <= '0;
			rate          <= '0;
			average       <= '0;
			last          <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			div_start_q  <= 1'b0;
			sum_vld_rd_q <= sum_vld_q[rd_addr];
			avg_vld_rd_q <= avg_vld_q[rd_addr];

			// Writes must arrive only while the block is idle; the block itself does not enforce this.
			if (cfg_we) begin
				unique case (cfg_index)
					tram_pkg::REG_PERIOD_MS:  period_q     <= cfg_data[PERIOD_W-1:0];
					tram_pkg::REG_REGRESSION: regression_q <= cfg_data[tram_pkg::REGR_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req_type == tram_pkg::REQ_TICK) begin
							idx_q   <= '0;
							dir_q   <= 1'b0;
							cat_q   <= '0;
							state_q <= ST_READ;
						end else if (in_range) begin
							idx_q   <= in_idx;
							add_q   <= VAL_W'(byte_count) << FRACTION_BITS;
							state_q <= ST_CNT_ADD;
						end
					end
				end
				ST_CNT_ADD: begin
					sum_vld_q[idx_q] <= 1'b1;
					state_q          <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q      <= prod;
					avg_old_q   <= avg_cur;
					div_start_q <= 1'b1;
					state_q     <= ST_DIV_RATE;
				end
				ST_DIV_RATE: begin
					if (div_done) begin
						rate_q      <= rate_sat;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV_AVG;
					end
				end
				ST_DIV_AVG: begin
					if (div_done) begin
						avg_dec_q   <= avg_old_q - quo_low;
						div_start_q <= 1'b1;
						state_q     <= ST_DIV_INC;
					end
				end
				ST_DIV_INC: begin
					if (div_done) begin
						// The new average goes to memory; the interval sum is cleared.
						sum_vld_q[idx_q] <= 1'b0;
						avg_vld_q[idx_q] <= 1'b1;
						result_valid     <= 1'b1;
						out_direction    <= dir_q;
						out_category     <= tram_pkg::CAT_W'(cat_q);
						rate             <= rate_q;
						average          <= avg_new;
						last             <= last_entry;
						if (last_entry) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
							if (cat_q == CAT_CNT_W'(NUM_CATEGORIES - 1)) begin
								cat_q <= '0;
								dir_q <= ~dir_q;
							end else begin
								cat_q <= cat_q + 1'b1;
							end
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- test/traffic_meter_checker.sv -----
module traffic_meter_checker #(
	parameter int NUM_DIRECTIONS = tram_pkg::DEF_NUM_DIRECTIONS,
	parameter int NUM_CATEGORIES = tram_pkg::DEF_NUM_CATEGORIES,
	parameter int FRACTION_BITS  = tram_pkg::DEF_FRACTION_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic                            req_type,
	input  logic                            direction,
	input  logic [tram_pkg::CAT_W-1:0]      category,
	input  logic [tram_pkg::BYTE_W-1:0]     byte_count,
	input  logic                            cfg_we,
	input  logic [tram_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tram_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            result_valid,
	input  logic                            out_direction,
	input  logic [tram_pkg::CAT_W-1:0]      out_category,
	input  logic [tram_pkg::VAL_W-1:0]      rate,
	input  logic [tram_pkg::VAL_W-1:0]      average,
	input  logic                            last,
	output int                              fail_count,
	output int                              pending
);

	localparam int          NUM_ENTRIES = NUM_DIRECTIONS * NUM_CATEGORIES;
	localparam logic [63:0] VAL_LIMIT   = {16'd0, tram_pkg::VAL_MAX};

	typedef struct packed {
		logic                         dir;
		logic [tram_pkg::CAT_W-1:0]   cat;
		logic [tram_pkg::VAL_W-1:0]   rate;
		logic [tram_pkg::VAL_W-1:0]   average;
		logic                         last;
	} meter_report_t;

	logic [tram_pkg::VAL_W-1:0]    interval_sums [NUM_ENTRIES];
	logic [tram_pkg::VAL_W-1:0]    rate_averages [NUM_ENTRIES];
	logic [tram_pkg::PERIOD_W-1:0] period_ms;
	logic [tram_pkg::REGR_W-1:0]   regression;
	meter_report_t                 expected_reports [$];

	// All sampling happens on the rising edge, so every value seen here is the one
	// the block itself sampled at that edge.
	always @(posedge clk or negedge arst_n) begin
		meter_report_t want;
		logic [63:0]   wide;
		logic [63:0]   divisor;
		logic [63:0]   weight;
		logic [63:0]   decayed;
		int            idx;
		if (!arst_n) begin
			period_ms  = tram_pkg::PERIOD_RESET;
			regression = tram_pkg::REGR_RESET;
			for (int e = 0; e < NUM_ENTRIES; e++) begin
				interval_sums[e] = '0;
				rate_averages[e] = '0;
			end
			expected_reports.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (result_valid) begin
				if (expected_reports.size() == 0) begin
					$error("result transfer with nothing expected: dir %0d cat %0d",
						out_direction, out_category);
					fail_count++;
				end else begin
					want = expected_reports.pop_front();
					if (out_direction !== want.dir) begin
						$error("out_direction: expected %0d, actual %0d", want.dir, out_direction);
						fail_count++;
					end
					if (out_category !== want.cat) begin
						$error("out_category: expected %0d, actual %0d", want.cat, out_category);
						fail_count++;
					end
					if (rate !== want.rate) begin
						$error("rate: expected %0d, actual %0d", want.rate, rate);
						fail_count++;
					end
					if (average !== want.average) begin
						$error("average: expected %0d, actual %0d", want.average, average);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, last);
						fail_count++;
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					tram_pkg::REG_PERIOD_MS:  period_ms  = cfg_data[tram_pkg::PERIOD_W-1:0];
					tram_pkg::REG_REGRESSION: regression = cfg_data[tram_pkg::REGR_W-1:0];
					default: ;
				endcase
			end

			if (start && !busy) begin
				if (req_type == tram_pkg::REQ_TICK) begin
					// Zero period or zero regression behaves as one.
					divisor = (period_ms == '0) ? 64'd1 : 64'(period_ms);
					weight  = (regression == '0) ? 64'd1 : 64'(regression);
					for (int e = 0; e < NUM_ENTRIES; e++) begin
						wide = 64'(interval_sums[e]) * 64'(tram_pkg::MS_PER_SECOND) / divisor;
						want.rate = (wide > VAL_LIMIT) ? tram_pkg::VAL_MAX : wide[47:0];
						decayed = 64'(rate_averages[e]);
						decayed = decayed - decayed / weight;
						wide = decayed + 64'(want.rate) / weight;
						want.average = (wide > VAL_LIMIT) ? tram_pkg::VAL_MAX : wide[47:0];
						want.dir  = 1'(e / NUM_CATEGORIES);
						want.cat  = tram_pkg::CAT_W'(e % NUM_CATEGORIES);
						want.last = (e == NUM_ENTRIES - 1);
						rate_averages[e] = want.average;
						interval_sums[e] = '0;
						expected_reports.push_back(want);
					end
				end else if (int'(direction) < NUM_DIRECTIONS &&
						int'(category) < NUM_CATEGORIES) begin
					idx  = int'(direction) * NUM_CATEGORIES + int'(category);
					wide = 64'(interval_sums[idx]) + (64'(byte_count) << FRACTION_BITS);
					interval_sums[idx] = (wide > VAL_LIMIT) ? tram_pkg::VAL_MAX : wide[47:0];
				end
			end
			pending = expected_reports.size();
		end
	end

endmodule

// ----- test/tb_traffic_rate_average_meter_core.sv -----
module tb_traffic_rate_average_meter_core;

	// Widths and codes taken from the package.
	localparam int   CAT_W      = tram_pkg::CAT_W;
	localparam int   BYTE_W     = tram_pkg::BYTE_W;
	localparam int   VAL_W      = tram_pkg::VAL_W;
	localparam int   CFG_IDX_W  = tram_pkg::CFG_IDX_W;
	localparam int   CFG_DATA_W = tram_pkg::CFG_DATA_W;
	localparam logic REQ_COUNT  = tram_pkg::REQ_COUNT;
	localparam logic REQ_TICK   = tram_pkg::REQ_TICK;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 2'd3;

	localparam int NUM_PHASES      = 7;
	localparam int ITEMS_PER_PHASE = 64;
	// A tick walks every entry and is slow, so the number of random ticks is
	// capped to keep the run short.
	localparam int TICK_CAP        = 60;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic                  req_type   = REQ_COUNT;
	logic                  direction  = 1'b0;
	logic [CAT_W-1:0]      category   = '0;
	logic [BYTE_W-1:0]     byte_count = '0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = tram_pkg::REG_PERIOD_MS;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	logic                  busy;
	logic                  result_valid;
	logic                  out_direction;
	logic [CAT_W-1:0]      out_category;
	logic [VAL_W-1:0]      rate;
	logic [VAL_W-1:0]      average;
	logic                  last;

	int fail_count;
	int pending;
	int ticks_sent = 0;

	// Register settings per phase. Phase 0 runs on the reset values and writes
	// nothing. Some regression entries carry bits above the register width so that
	// masking is exercised; 20'hFFC00 lands on 1024 and 20'hFF800 on zero.
	logic [CFG_DATA_W-1:0] phase_period [NUM_PHASES] = '{
		20'd1000, 20'd1, 20'd1000000, 20'd0, 20'hFFFFF, 20'd0, 20'd1000
	};
	logic [CFG_DATA_W-1:0] phase_regression [NUM_PHASES] = '{
		20'd16, 20'd1, 20'hFFC00, 20'hFF800, 20'd2047, 20'd0, 20'd16
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	traffic_rate_average_meter_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.direction    (direction),
		.category     (category),
		.byte_count   (byte_count),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.out_direction(out_direction),
		.out_category (out_category),
		.rate         (rate),
		.average      (average),
		.last         (last)
	);

	traffic_meter_checker meter_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.direction    (direction),
		.category     (category),
		.byte_count   (byte_count),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.out_direction(out_direction),
		.out_category (out_category),
		.rate         (rate),
		.average      (average),
		.last         (last),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Presents one command and returns on the rising edge at which it is taken.
	// Busy is looked at on the falling edge, where it is stable, so the edge that
	// follows a low busy is known to complete the transfer. Start is left high so
	// that a following command keeps the channel busy without a bubble.
	task automatic send_item(input logic kind, input logic dir, input logic [CAT_W-1:0] cat,
			input logic [BYTE_W-1:0] bytes);
		start      <= 1'b1;
		req_type   <= kind;
		direction  <= dir;
		category   <= cat;
		byte_count <= bytes;
		@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
		if (kind == REQ_TICK)
			ticks_sent++;
	endtask

	// Drops start for a number of cycles; a zero gap leaves start untouched so
	// that it is never lowered and raised within one time step.
	task automatic idle_cycles(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Holds off the sender until every expected result has been seen and the
	// block has gone idle. A count command yields no result but keeps the block
	// busy for one cycle, so a short extra pause follows before any write.
	task automatic drain_meter();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// A register write takes one cycle with the enable high and one with it low,
	// so back-to-back writes never assign the enable twice in one step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Byte counts lean on the extremes and on packet-like sizes, with the rest
	// spread over the whole field.
	function automatic logic [BYTE_W-1:0] pick_bytes();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2, 3:    return BYTE_W'($urandom_range(0, 1500));
			default: return BYTE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Random traffic in bursts. Most of it looks like real packets: a payload
	// count followed by the packet header and frame header counts of the same
	// direction. The rest is single counts on any entry and the odd tick. Gaps
	// between bursts are random, and some bursts run long with no gap at all.
	task automatic send_random_traffic(input int items);
		int   sent;
		int   burst_left;
		logic dir;
		sent       = 0;
		burst_left = 0;
		while (sent < items) begin
			if (burst_left <= 0) begin
				idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 10);
			end
			dir = 1'($urandom_range(0, 1));
			if (ticks_sent < TICK_CAP && $urandom_range(0, 24) == 0) begin
				send_item(REQ_TICK, dir, CAT_W'($urandom_range(0, 15)),
					BYTE_W'($urandom_range(0, 65535)));
				sent++;
				burst_left--;
			end else if ($urandom_range(0, 9) < 6) begin
				send_item(REQ_COUNT, dir, CAT_W'(0), pick_bytes());
				send_item(REQ_COUNT, dir, CAT_W'(1), BYTE_W'($urandom_range(20, 60)));
				send_item(REQ_COUNT, dir, CAT_W'(2), BYTE_W'($urandom_range(14, 30)));
				sent       += 3;
				burst_left -= 3;
			end else begin
				send_item(REQ_COUNT, dir, CAT_W'($urandom_range(0, 15)), pick_bytes());
				sent++;
				burst_left--;
			end
		end
	endtask

	initial begin
		int waited;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed opening on the reset settings. A tick on empty sums reports all
		// zeros; then the extremes of every field, counts piling up on one entry,
		// and a tick whose ignored fields are all ones. The third tick shows the
		// average decaying while the rate drops to zero.
		send_item(REQ_TICK, 1'b0, CAT_W'(0), '0);
		send_item(REQ_COUNT, 1'b0, CAT_W'(0), '1);
		send_item(REQ_COUNT, 1'b0, CAT_W'(0), '1);
		send_item(REQ_COUNT, 1'b1, CAT_W'(15), '1);
		send_item(REQ_COUNT, 1'b0, CAT_W'(15), '0);
		send_item(REQ_COUNT, 1'b1, CAT_W'(0), BYTE_W'(1));
		send_item(REQ_COUNT, 1'b1, CAT_W'(7), 16'h5555);
		send_item(REQ_COUNT, 1'b0, CAT_W'(8), 16'hAAAA);
		send_item(REQ_COUNT, 1'b0, CAT_W'(1), BYTE_W'(40));
		send_item(REQ_COUNT, 1'b0, CAT_W'(2), BYTE_W'(18));
		send_item(REQ_TICK, 1'b1, CAT_W'(15), '1);
		send_item(REQ_TICK, 1'b0, CAT_W'(0), '0);

		// Each phase after the first programs both registers while the block is idle;
		// every phase runs random traffic and closes with a tick so that the sums of
		// the phase are reported under its own settings.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				drain_meter();
				if (p == 5) begin
					phase_period[p]     = CFG_DATA_W'($urandom_range(1, 1000000));
					phase_regression[p] = CFG_DATA_W'($urandom_range(1, 1024));
				end
				write_reg(tram_pkg::REG_PERIOD_MS, phase_period[p]);
				write_reg(tram_pkg::REG_REGRESSION, phase_regression[p]);
				if (p == NUM_PHASES - 1) begin
					// Writes past the register list carry random data and must leave
					// both registers as they are.
					write_reg(REG_SPARE_LOW, CFG_DATA_W'($urandom_range(0, 1048575)));
					write_reg(REG_SPARE_HIGH, CFG_DATA_W'($urandom_range(0, 1048575)));
				end
			end
			if (p == 2) begin
				// Mid-phase the sender waits until every expected result is in.
				send_random_traffic(ITEMS_PER_PHASE / 2);
				drain_meter();
				send_random_traffic(ITEMS_PER_PHASE / 2);
			end else begin
				send_random_traffic(ITEMS_PER_PHASE);
			end
			send_item(REQ_TICK, 1'($urandom_range(0, 1)), CAT_W'($urandom_range(0, 15)),
				BYTE_W'($urandom_range(0, 65535)));
		end

		// Wait for the remaining results with a bounded loop, then give the block
		// a short tail to show any stray result transfer.
		start <= 1'b0;
		waited = 0;
		@(negedge clk);
		while ((pending != 0 || busy) && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (50) @(posedge clk);

		if (fail_count == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog: the slowest correct run stays well below this bound.
	initial begin
		#20000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/tram_pkg.sv
design/tram_ram.sv
design/tram_div.sv
design/traffic_rate_average_meter_core.sv
test/traffic_meter_checker.sv
test/tb_traffic_rate_average_meter_core.sv
